FILE: rtl/core/tbs_pkg.sv
// Package for the throughput bitrate selector: widths, fixed-point
// coefficients, register indexes and the safety-factor type.
// Has no dependencies; used by throughput_bitrate_selector_top.
`default_nettype none

package tbs_pkg;

    // Field widths.
    localparam int LEVEL_W   = 10;
    localparam int RATE_W    = 32;
    localparam int SEG_W     = 16;
    localparam int IDX_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    // Representation count in use and storage provided.
    localparam int NUM_REPS = 6;
    localparam int MAX_REPS = 6;

    // Smoothed rate in unsigned Q32.FRAC_BITS, held in 48 bits.
    localparam int FRAC_BITS = 16;
    localparam int SM_W      = 48;
    localparam int MUL_W     = SM_W + FRAC_BITS;
    localparam int CMP_W     = SM_W + 2;

    // Smoothing weights, 0.7 and 0.3, summing exactly to one.
    localparam longint ONE_Q    = longint'(1) << FRAC_BITS;
    localparam longint COEF_OLD = ((longint'(7) << FRAC_BITS) + 5) / 10;
    localparam longint COEF_NEW = ONE_Q - COEF_OLD;

    // Buffer thresholds for the safety factor.
    localparam int LOW_BUFFER = 4;
    localparam int MID_BUFFER = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SEGMENTS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_0         = 3'd1;

    // Safety factor picked by the buffer level.
    typedef enum logic [1:0] {
        FACTOR_HALF,
        FACTOR_3Q,
        FACTOR_ONE
    } t_factor;

endpackage

`default_nettype wire

FILE: rtl/core/throughput_bitrate_selector_top.sv
// Top level of the throughput bitrate selector: a three-register pipeline
// with smoothing, representation choice and configuration registers.
// Depends on tbs_pkg.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_buffer_level, i_download_rate
//  out     | output    | o_out_valid / i_out_ready  | o_all_done, o_rep_index,
//          |           |                            | o_rep_bitrate, o_segment_number
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One word is accepted each cycle unless stalled; it moves via stage 1, stage 2, output.
// The smoothing feedback closes within the first stage through the smoothed-rate
// register, so consecutive words see each other's update with no gap.
// A stalled output holds its word; a full pipe stalls the input in the same cycle.
// Synchronous active-low reset clears the state, the stage valids and the
// configuration registers.
`default_nettype none

module throughput_bitrate_selector_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Request channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [tbs_pkg::LEVEL_W-1:0]  i_buffer_level,
    input  wire logic [tbs_pkg::RATE_W-1:0]   i_download_rate,
    // Result channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_all_done,
    output logic [tbs_pkg::IDX_W-1:0]         o_rep_index,
    output logic [tbs_pkg::RATE_W-1:0]        o_rep_bitrate,
    output logic [tbs_pkg::SEG_W-1:0]         o_segment_number,
    // Configuration channel
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [tbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tbs_pkg::CFG_W-1:0]    i_cfg_data
);

    import tbs_pkg::*;

    // Configuration and state registers.
    logic [SEG_W-1:0]  r_total;
    logic [RATE_W-1:0] r_rates [MAX_REPS];
    logic [SM_W-1:0]   r_sm;
    logic [SM_W-1:0]   n_sm;
    logic [SEG_W-1:0]  r_seg;

    // Derived from the rates: pairwise order and lowest representation.
    logic [NUM_REPS-1:0] r_lt [NUM_REPS];
    logic [NUM_REPS-1:0] n_lt [NUM_REPS];
    logic [IDX_W-1:0]    r_low;
    logic [IDX_W-1:0]    n_low;

    // Stage 1: accepted request.
    logic               r_s1_valid;
    logic [LEVEL_W-1:0] r_s1_level;
    logic [RATE_W-1:0]  r_s1_rate;

    // Stage 2: smoothed rate and factor.
    logic             r_s2_valid;
    logic             r_s2_done;
    t_factor          r_s2_factor;
    t_factor          n_factor;
    logic [SM_W-1:0]  r_s2_sm;
    logic [SEG_W-1:0] r_s2_seg;

    // Output register.
    logic              r_out_valid;
    logic              r_out_done;
    logic [IDX_W-1:0]  r_out_index;
    logic [RATE_W-1:0] r_out_bitrate;
    logic [SEG_W-1:0]  r_out_seg;

    // Flow control.
    logic out_en;
    logic s2_en;
    logic s1_en;
    logic s1_fire;
    logic s1_done;

    // Selection logic in stage 2.
    logic [CMP_W-1:0]    sm_cmp;
    logic [NUM_REPS-1:0] cand;
    logic [NUM_REPS-1:0] win;
    logic [IDX_W-1:0]    win_index;
    logic [IDX_W-1:0]    pick;

    // Each stage moves when the stage after it can take its word.
    assign out_en     = !r_out_valid || i_out_ready;
    assign s2_en      = !r_s2_valid || out_en;
    assign s1_en      = !r_s1_valid || s2_en;
    assign s1_fire    = r_s1_valid && s2_en;
    assign o_in_ready = s1_en;
    assign o_cfg_ready = 1'b1;

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            for (int i = 0; i < MAX_REPS; i++) begin
                r_rates[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_TOTAL_SEGMENTS) begin
                r_total <= i_cfg_data[SEG_W-1:0];
            end
            for (int i = 0; i < MAX_REPS; i++) begin
                if (i_cfg_index == REG_RATE_0 + CFG_IDX_W'(i)) begin
                    r_rates[i] <= i_cfg_data[RATE_W-1:0];
                end
            end
        end
    end

    // Pairwise order of the rates and the lowest one, first index on ties.
    always_comb begin
        logic is_low;
        n_low = '0;
        for (int i = 0; i < NUM_REPS; i++) begin
            for (int j = 0; j < NUM_REPS; j++) begin
                n_lt[i][j] = r_rates[i] < r_rates[j];
            end
        end
        for (int i = 0; i < NUM_REPS; i++) begin
            is_low = 1'b1;
            for (int j = 0; j < NUM_REPS; j++) begin
                if (j < i && !n_lt[i][j]) begin
                    is_low = 1'b0;
                end
                if (j > i && n_lt[j][i]) begin
                    is_low = 1'b0;
                end
            end
            if (is_low) begin
                n_low = n_low | IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lt  <= n_lt;
        r_low <= n_low;
    end

    // Stage 1 load.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_en) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en && i_in_valid) begin
            r_s1_level <= i_buffer_level;
            r_s1_rate  <= i_download_rate;
        end
    end

    // Smoothing: 0.7 * previous + 0.3 * new, seeded with the new rate.
    // The new term is exact in fixed point, so only the old term is floored.
    always_comb begin
        logic [MUL_W-1:0] prod_old;
        logic [SM_W-1:0]  term_new;
        prod_old = MUL_W'(COEF_OLD) * MUL_W'(r_sm);
        term_new = SM_W'(COEF_NEW) * SM_W'(r_s1_rate);
        if (r_sm == '0) begin
            n_sm = SM_W'(r_s1_rate) << FRAC_BITS;
        end else begin
            n_sm = SM_W'(prod_old >> FRAC_BITS) + term_new;
        end
    end

    // Safety factor from the buffer level.
    always_comb begin
        if (r_s1_level < LEVEL_W'(LOW_BUFFER)) begin
            n_factor = FACTOR_HALF;
        end else if (r_s1_level < LEVEL_W'(MID_BUFFER)) begin
            n_factor = FACTOR_3Q;
        end else begin
            n_factor = FACTOR_ONE;
        end
    end

    assign s1_done = r_seg >= r_total;

    // State update: only a request that issues a segment changes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sm  <= '0;
            r_seg <= '0;
        end else if (s1_fire && !s1_done) begin
            r_sm  <= n_sm;
            r_seg <= r_seg + SEG_W'(1);
        end
    end

    // Stage 2 load.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_s2_done   <= s1_done;
            r_s2_factor <= n_factor;
            r_s2_sm     <= n_sm;
            r_s2_seg    <= r_seg;
        end
    end

    // Threshold test per representation; a zero rate is never a candidate.
    always_comb begin
        logic [CMP_W-1:0] rate_q;
        sm_cmp = CMP_W'(r_s2_sm);
        if (r_s2_factor == FACTOR_3Q) begin
            sm_cmp = CMP_W'(r_s2_sm) + (CMP_W'(r_s2_sm) << 1);
        end
        for (int i = 0; i < NUM_REPS; i++) begin
            rate_q = CMP_W'(r_rates[i]) << FRAC_BITS;
            case (r_s2_factor)
                FACTOR_HALF: rate_q = CMP_W'(r_rates[i]) << (FRAC_BITS + 1);
                FACTOR_3Q:   rate_q = CMP_W'(r_rates[i]) << (FRAC_BITS + 2);
                default:     rate_q = CMP_W'(r_rates[i]) << FRAC_BITS;
            endcase
            cand[i] = (rate_q < sm_cmp) && (r_rates[i] != '0);
        end
    end

    // Highest candidate wins; among equal rates the lowest index wins.
    always_comb begin
        win_index = '0;
        for (int i = 0; i < NUM_REPS; i++) begin
            win[i] = cand[i];
            for (int j = 0; j < NUM_REPS; j++) begin
                if (j < i && cand[j] && !r_lt[j][i]) begin
                    win[i] = 1'b0;
                end
                if (j > i && cand[j] && r_lt[i][j]) begin
                    win[i] = 1'b0;
                end
            end
            if (win[i]) begin
                win_index = win_index | IDX_W'(i);
            end
        end
        pick = (|win) ? win_index : r_low;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en && r_s2_valid) begin
            r_out_done <= r_s2_done;
            if (r_s2_done) begin
                r_out_index   <= '0;
                r_out_bitrate <= '0;
                r_out_seg     <= '0;
            end else begin
                r_out_index   <= pick;
                r_out_bitrate <= r_rates[pick];
                r_out_seg     <= r_s2_seg;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_all_done       = r_out_done;
    assign o_rep_index      = r_out_index;
    assign o_rep_bitrate    = r_out_bitrate;
    assign o_segment_number = r_out_seg;

`ifndef SYNTHESIS
    // A finished presentation reports all-zero fields.
    a_done_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_all_done |->
            o_rep_index == '0 && o_rep_bitrate == '0 && o_segment_number == '0)
        else $error("done result carries nonzero fields");

    // A chosen representation is always one in use.
    a_index_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_all_done |-> o_rep_index < IDX_W'(NUM_REPS))
        else $error("representation index out of range");

    // At most one representation wins the search.
    a_win_onehot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> $onehot0(win))
        else $error("more than one winning representation");

    // The segment counter moves only by one, and only on an issuing request.
    a_seg_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_seg != $past(r_seg) |->
            r_seg == $past(r_seg) + SEG_W'(1) && $past(s1_fire) && !$past(s1_done))
        else $error("segment counter stepped unexpectedly");
`endif

endmodule

`default_nettype wire
